### rtl/svrp_pkg.sv
// ----------------------------------------------------------------------------
// svrp_pkg
// Shared types and constants of the stepper velocity ramp and period block.
// ----------------------------------------------------------------------------
`default_nettype none

package svrp_pkg;

  localparam int VEL_W    = 27;
  localparam int ACC_W    = 16;
  localparam int SPR_W    = 16;
  localparam int CLK_W    = 27;
  localparam int PER_W    = 16;
  localparam int NUM_W    = CLK_W + 16;
  localparam int DEN_W    = VEL_W + SPR_W;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W    = $clog2(DIV_STEPS);

  localparam logic [2:0] REG_TARGET_VELOCITY = 3'd0;
  localparam logic [2:0] REG_ACCEL_PER_TICK  = 3'd1;
  localparam logic [2:0] REG_STEPS_PER_REV   = 3'd2;
  localparam logic [2:0] REG_TIMER_CLOCK_HZ  = 3'd3;
  localparam logic [2:0] REG_MIN_PERIOD      = 3'd4;

  typedef enum logic {
    OP_HOLD,
    OP_RAMP
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] target_velocity;
    logic [ACC_W-1:0]        accel_per_tick;
    logic [SPR_W-1:0]        steps_per_rev;
    logic [CLK_W-1:0]        timer_clock_hz;
    logic [PER_W-1:0]        min_period;
  } cfg_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

endpackage

`default_nettype wire

### rtl/stepper_velocity_ramp_period.sv
// ----------------------------------------------------------------------------
// stepper_velocity_ramp_period
// Trapezoidal velocity ramp with step timer period for a stepper motor.
//
// Input channel: in_valid / in_stall with one field, tick. A tick of one moves
// the velocity toward target_velocity by at most accel_per_tick, landing on it
// exactly; a tick of zero holds the velocity. Every input transfer yields one
// output transfer on out_valid / out_stall carrying forward, step_period and
// velocity_now. The period is timer_clock_hz * 65536 / (|v| * steps_per_rev),
// clamped to [min_period, 65535], and 1 at zero speed.
// The back end takes one item at a time: it starts a new item only after the
// 43-step restoring divider has finished the last one and its output is loaded.
// Items accepted meanwhile wait in the front register and the queue.
// Reset clears the velocity and loads the register defaults. A stalled output
// holds its values; the back end waits for it while the front keeps taking
// items until the queue fills. Registers sit on the APB-style port at 4*i.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_velocity_ramp_period
  import svrp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              tick,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   forward,
  output logic [PER_W-1:0]       step_period,
  output logic signed [VEL_W-1:0] velocity_now
);

  cfg_t        cfg;
  logic        push;
  op_t         push_op;
  logic        queue_full;
  logic        pop;
  queue_head_t head;

  svrp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  svrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .tick       (tick),
    .push       (push),
    .push_op    (push_op),
    .queue_full (queue_full)
  );

  svrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (queue_full),
    .pop     (pop),
    .head    (head)
  );

  svrp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .forward      (forward),
    .step_period  (step_period),
    .velocity_now (velocity_now)
  );

endmodule

`default_nettype wire

### rtl/svrp_regs.sv
// ----------------------------------------------------------------------------
// svrp_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module svrp_regs
  import svrp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_velocity <= '0;
      cfg.accel_per_tick  <= ACC_W'(262);
      cfg.steps_per_rev   <= SPR_W'(10000);
      cfg.timer_clock_hz  <= CLK_W'(2000000);
      cfg.min_period      <= PER_W'(20);
    end else if (wr_en) begin
      unique case (idx)
        REG_TARGET_VELOCITY: cfg.target_velocity <= pwdata[VEL_W-1:0];
        REG_ACCEL_PER_TICK:  cfg.accel_per_tick  <= pwdata[ACC_W-1:0];
        REG_STEPS_PER_REV:   cfg.steps_per_rev   <= pwdata[SPR_W-1:0];
        REG_TIMER_CLOCK_HZ:  cfg.timer_clock_hz  <= pwdata[CLK_W-1:0];
        REG_MIN_PERIOD:      cfg.min_period      <= pwdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TARGET_VELOCITY: prdata = DATA_W'(cfg.target_velocity);
      REG_ACCEL_PER_TICK:  prdata = DATA_W'(cfg.accel_per_tick);
      REG_STEPS_PER_REV:   prdata = DATA_W'(cfg.steps_per_rev);
      REG_TIMER_CLOCK_HZ:  prdata = DATA_W'(cfg.timer_clock_hz);
      REG_MIN_PERIOD:      prdata = DATA_W'(cfg.min_period);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/svrp_front.sv
// ----------------------------------------------------------------------------
// svrp_front
// Input register: take tick items and classify them as ramp or hold.
// ----------------------------------------------------------------------------
`default_nettype none

module svrp_front
  import svrp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic tick,
  output logic      push,
  output op_t       push_op,
  input  wire logic queue_full
);

  logic held;
  op_t  op;
  logic accept;

  assign in_stall = held && queue_full;
  assign accept   = in_valid && !in_stall;
  assign push     = held && !queue_full;
  assign push_op  = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= tick ? OP_RAMP : OP_HOLD;
    end
  end

endmodule

`default_nettype wire

### rtl/svrp_queue.sv
// ----------------------------------------------------------------------------
// svrp_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module svrp_queue
  import svrp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire op_t   push_op,
  output logic       full,
  input  wire logic  pop,
  output queue_head_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_t           entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.op    = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

`default_nettype wire

### rtl/svrp_back.sv
// ----------------------------------------------------------------------------
// svrp_back
// Ramp the velocity, form the divisor and divide one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module svrp_back
  import svrp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire queue_head_t head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             forward,
  output logic [PER_W-1:0] step_period,
  output logic signed [VEL_W-1:0] velocity_now
);

  back_state_t state;
  back_state_t state_next;

  logic signed [VEL_W-1:0] velocity;
  logic signed [VEL_W-1:0] velocity_next;
  logic [DEN_W-1:0]        den;
  logic [DEN_W:0]          rem;
  logic [NUM_W-1:0]        quo;
  logic [CNT_W-1:0]        cnt;
  logic                    out_free;
  logic                    load_out;
  logic                    start_mul;
  logic                    run_div;

  logic signed [VEL_W:0]   up_sum;
  logic signed [VEL_W:0]   dn_sum;
  logic signed [VEL_W:0]   tgt_x;
  logic [VEL_W-1:0]        mag;
  logic [DEN_W+1:0]        trial;
  logic [PER_W-1:0]        period;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    tgt_x  = {cfg.target_velocity[VEL_W-1], cfg.target_velocity};
    up_sum = {velocity[VEL_W-1], velocity} + $signed({(VEL_W+1-ACC_W)'(0), cfg.accel_per_tick});
    dn_sum = {velocity[VEL_W-1], velocity} - $signed({(VEL_W+1-ACC_W)'(0), cfg.accel_per_tick});
    velocity_next = velocity;
    if (head.op == OP_RAMP) begin
      if (velocity < cfg.target_velocity) begin
        velocity_next = (up_sum < tgt_x) ? up_sum[VEL_W-1:0] : cfg.target_velocity;
      end else if (velocity > cfg.target_velocity) begin
        velocity_next = (dn_sum > tgt_x) ? dn_sum[VEL_W-1:0] : cfg.target_velocity;
      end
    end
  end

  assign mag   = velocity[VEL_W-1] ? VEL_W'(-velocity) : VEL_W'(velocity);
  assign trial = {1'b0, rem[DEN_W-1:0], quo[NUM_W-1]} - {2'b00, den};

  always_comb begin
    if (den == '0) begin
      period = PER_W'(1);
    end else if (|quo[NUM_W-1:PER_W]) begin
      period = '1;
    end else if (quo[PER_W-1:0] < cfg.min_period) begin
      period = cfg.min_period;
    end else begin
      period = quo[PER_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (head.valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    start_mul = 1'b0;
    run_div   = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: pop       = head.valid;
      ST_MUL:  start_mul = 1'b1;
      ST_DIV:  run_div   = 1'b1;
      ST_DONE: load_out  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      velocity  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        velocity <= velocity_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_mul) begin
      den <= {{SPR_W{1'b0}}, mag} * {{VEL_W{1'b0}}, cfg.steps_per_rev};
      rem <= '0;
      quo <= {cfg.timer_clock_hz, 16'h0000};
      cnt <= '0;
    end else if (run_div) begin
      cnt <= cnt + 1'b1;
      if (!trial[DEN_W+1]) begin
        rem <= trial[DEN_W:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DEN_W-1:0], quo[NUM_W-1]};
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      forward      <= !velocity[VEL_W-1];
      step_period  <= period;
      velocity_now <= velocity;
    end
  end

endmodule

`default_nettype wire

### tb/stepper_velocity_ramp_period_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_velocity_ramp_period_tb
// Self-checking bench for the stepper velocity ramp and step period block.
// A local ramp predictor tracks velocity and register settings, computes the
// expected direction, period and velocity for every tick transfer, and a
// monitor compares each output transfer in order. Ticks at the defaults, then
// directed register extremes and ramp landings come first, then a forced
// output hold-off, then random register settings with random tick streams
// under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module stepper_velocity_ramp_period_tb;
  import svrp_pkg::*;

  typedef struct packed {
    logic                    fwd;
    logic [PER_W-1:0]        period;
    logic signed [VEL_W-1:0] vel;
  } ramp_result_t;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int     CLK_HALF     = 6;
  localparam int     RST_CYCLES   = 11;
  localparam int     DRAIN_CYCLES = 60;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     RANDOM_ITEMS = 1100;
  localparam longint LIMIT_NS     = 15_000_000;
  localparam longint VEL_MAX      = (longint'(1) << (VEL_W - 1)) - 1;
  localparam longint VEL_MIN      = -(longint'(1) << (VEL_W - 1));
  localparam longint CLK_MAX      = (longint'(1) << CLK_W) - 1;
  localparam longint PER_MAX      = (longint'(1) << PER_W) - 1;
  localparam longint FIELD16_MAX  = 65535;

  logic                    clk;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid;
  logic                    in_stall;
  logic                    tick;
  logic                    out_valid;
  logic                    out_stall;
  logic                    forward;
  logic [PER_W-1:0]        step_period;
  logic signed [VEL_W-1:0] velocity_now;

  // predictor copy of the registers and the ramp state
  logic signed [VEL_W-1:0] rc_target;
  logic [ACC_W-1:0]        rc_accel;
  logic [SPR_W-1:0]        rc_spr;
  logic [CLK_W-1:0]        rc_tclk;
  logic [PER_W-1:0]        rc_minp;
  longint                  ramp_vel;

  ramp_result_t ramp_expect_q[$];
  int           mismatches;
  int           burst_left;
  bit           back_to_back;
  bit           hold_request;

  stepper_velocity_ramp_period u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .tick         (tick),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .forward      (forward),
    .step_period  (step_period),
    .velocity_now (velocity_now)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic ramp_result_t predict_ramp(input bit tk);
    longint            tgt;
    longint            acc;
    longint            nxt;
    longint            mag;
    longint unsigned   den;
    longint unsigned   quo;
    longint unsigned   num;
    ramp_result_t      r;
    tgt = rc_target;
    acc = rc_accel;
    if (tk) begin
      if (ramp_vel < tgt) begin
        nxt = ramp_vel + acc;
        ramp_vel = (nxt < tgt) ? nxt : tgt;
      end else if (ramp_vel > tgt) begin
        nxt = ramp_vel - acc;
        ramp_vel = (nxt > tgt) ? nxt : tgt;
      end
    end
    mag = (ramp_vel < 0) ? -ramp_vel : ramp_vel;
    den = mag;
    den = den * rc_spr;
    if (den == 0) begin
      quo = 1;
    end else begin
      num = rc_tclk;
      quo = (num << 16) / den;
      if (quo < rc_minp) quo = rc_minp;
      if (quo > PER_MAX) quo = PER_MAX;
    end
    r.fwd    = (ramp_vel >= 0);
    r.period = quo[PER_W-1:0];
    r.vel    = ramp_vel[VEL_W-1:0];
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pad_junk(input longint field, input int width);
    logic [DATA_W-1:0] keep;
    logic [DATA_W-1:0] junk;
    keep = '1;
    keep = keep >> (DATA_W - width);
    junk = $urandom;
    return (junk & ~keep) | (field[DATA_W-1:0] & keep);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // output monitor
  initial begin
    ramp_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (ramp_expect_q.size() == 0) begin
          report_mismatch("unexpected transfer, velocity", velocity_now, 0);
        end else begin
          want = ramp_expect_q.pop_front();
          if (forward !== want.fwd)
            report_mismatch("forward", forward, want.fwd);
          if (step_period !== want.period)
            report_mismatch("step_period", step_period, want.period);
          if (velocity_now !== want.vel)
            report_mismatch("velocity_now", velocity_now, want.vel);
        end
      end
    end
  end

  // output stall pattern, with a long hold-off on request
  initial begin
    int stall_pct;
    int pattern_left;
    stall_pct = 0;
    pattern_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (pattern_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
          endcase
          pattern_left = $urandom_range(20, 200);
        end
        pattern_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_TARGET_VELOCITY: rc_target = value[VEL_W-1:0];
      REG_ACCEL_PER_TICK:  rc_accel  = value[ACC_W-1:0];
      REG_STEPS_PER_REV:   rc_spr    = value[SPR_W-1:0];
      REG_TIMER_CLOCK_HZ:  rc_tclk   = value[CLK_W-1:0];
      REG_MIN_PERIOD:      rc_minp   = value[PER_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_tick(input bit tk);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    tick     <= tk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ramp_expect_q.push_back(predict_ramp(tk));
    if (back_to_back) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 10);
      @(negedge clk);
      in_valid <= 1'b0;
      tick     <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // drop valid and wait until every expected transfer is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    tick     <= 1'b0;
    while (ramp_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_hold_at_defaults();
    send_tick(1'b0);
    send_tick(1'b1);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_TARGET_VELOCITY, VEL_MAX[DATA_W-1:0]);
    write_reg(REG_ACCEL_PER_TICK, FIELD16_MAX[DATA_W-1:0]);
    write_reg(REG_STEPS_PER_REV, FIELD16_MAX[DATA_W-1:0]);
    write_reg(REG_TIMER_CLOCK_HZ, CLK_MAX[DATA_W-1:0]);
    write_reg(REG_MIN_PERIOD, 32'd1);
    repeat (3) send_tick(1'b1);
    drain();
    // accel of zero freezes the velocity
    write_reg(REG_ACCEL_PER_TICK, 32'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();
    // zero steps per rev gives the stopped period
    write_reg(REG_STEPS_PER_REV, 32'd0);
    send_tick(1'b1);
    drain();
    // zero clock and no lower clamp give a zero period
    write_reg(REG_STEPS_PER_REV, 32'd1);
    write_reg(REG_TIMER_CLOCK_HZ, 32'd0);
    write_reg(REG_MIN_PERIOD, 32'd0);
    send_tick(1'b1);
    drain();
    // upper clamp
    write_reg(REG_TIMER_CLOCK_HZ, CLK_MAX[DATA_W-1:0]);
    write_reg(REG_MIN_PERIOD, 32'd1);
    send_tick(1'b1);
    drain();
    // lower clamp at its largest
    write_reg(REG_STEPS_PER_REV, FIELD16_MAX[DATA_W-1:0]);
    write_reg(REG_TIMER_CLOCK_HZ, 32'd1);
    write_reg(REG_MIN_PERIOD, FIELD16_MAX[DATA_W-1:0]);
    send_tick(1'b1);
    drain();
    write_reg(REG_STEPS_PER_REV, 32'd10000);
    write_reg(REG_TIMER_CLOCK_HZ, 32'd2000000);
    write_reg(REG_MIN_PERIOD, 32'd20);
  endtask

  task automatic test_ramp_landing();
    longint above;
    above = ramp_vel + 100;
    write_reg(REG_ACCEL_PER_TICK, FIELD16_MAX[DATA_W-1:0]);
    write_reg(REG_TARGET_VELOCITY, above[DATA_W-1:0]);
    send_tick(1'b1);
    drain();
    write_reg(REG_TARGET_VELOCITY, 32'd150000);
    send_tick(1'b1);
    drain();
    // ramp down through zero toward the most negative target
    write_reg(REG_TARGET_VELOCITY, VEL_MIN[DATA_W-1:0]);
    repeat (4) send_tick(1'b1);
    drain();
    // a write past the last register changes nothing
    write_reg(REG_UNUSED, $urandom);
    send_tick(1'b1);
    drain();
    write_reg(REG_TARGET_VELOCITY, 32'd0);
    repeat (2) send_tick(1'b1);
    drain();
  endtask

  task automatic test_input_backpressure();
    write_reg(REG_TARGET_VELOCITY, 32'd3000000);
    write_reg(REG_ACCEL_PER_TICK, 32'd5000);
    hold_request = 1'b1;
    back_to_back = 1'b1;
    repeat (12) send_tick($urandom_range(0, 4) != 0);
    back_to_back = 1'b0;
    drain();
  endtask

  task automatic apply_random_config();
    longint tv;
    longint av;
    longint sv;
    longint cv;
    longint mv;
    case ($urandom_range(0, 9))
      0: tv = VEL_MAX;
      1: tv = VEL_MIN;
      2: tv = 0;
      3, 4, 5: tv = $urandom;
      default: begin
        tv = $urandom_range(0, 3000000);
        if ($urandom_range(0, 1)) tv = -tv;
      end
    endcase
    case ($urandom_range(0, 9))
      0: av = 0;
      1, 2, 3: av = FIELD16_MAX;
      4, 5, 6: av = $urandom_range(1, 2000);
      default: av = $urandom_range(1, FIELD16_MAX);
    endcase
    case ($urandom_range(0, 9))
      0: sv = 0;
      1, 2: sv = 10000;
      3: sv = FIELD16_MAX;
      default: sv = $urandom_range(1, FIELD16_MAX);
    endcase
    case ($urandom_range(0, 9))
      0: cv = 0;
      1, 2: cv = 2000000;
      3: cv = CLK_MAX;
      default: cv = $urandom_range(1, CLK_MAX);
    endcase
    case ($urandom_range(0, 9))
      0: mv = 0;
      1, 2: mv = 20;
      3: mv = FIELD16_MAX;
      4, 5, 6: mv = $urandom_range(1, 300);
      default: mv = $urandom_range(1, FIELD16_MAX);
    endcase
    write_reg(REG_TARGET_VELOCITY, pad_junk(tv, VEL_W));
    write_reg(REG_ACCEL_PER_TICK, pad_junk(av, ACC_W));
    write_reg(REG_STEPS_PER_REV, pad_junk(sv, SPR_W));
    write_reg(REG_TIMER_CLOCK_HZ, pad_junk(cv, CLK_W));
    write_reg(REG_MIN_PERIOD, pad_junk(mv, PER_W));
  endtask

  task automatic test_random_ramps();
    int n;
    int sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      apply_random_config();
      n = $urandom_range(10, 80);
      repeat (n) send_tick($urandom_range(0, 9) != 0);
      sent += n;
      drain();
    end
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    tick         = 1'b0;
    mismatches   = 0;
    burst_left   = 0;
    back_to_back = 1'b0;
    hold_request = 1'b0;
    rc_target    = '0;
    rc_accel     = 16'd262;
    rc_spr       = 16'd10000;
    rc_tclk      = 27'd2000000;
    rc_minp      = 16'd20;
    ramp_vel     = 0;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_hold_at_defaults();
    test_register_extremes();
    test_ramp_landing();
    test_input_backpressure();
    test_random_ramps();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
